// ===== hw/rtl/ffra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants of the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int MaxRegions = 16;
    localparam int HeapBytes  = 1048576;
    localparam int IdxW       = $clog2(MaxRegions);
    localparam int CntW       = $clog2(MaxRegions + 1);
    localparam int OffW       = 20;
    localparam int LenW       = 21;
    localparam int EndW       = 22;

    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StFull     = 2'd1;
    localparam logic [1:0] StNoFit    = 2'd2;
    localparam logic [1:0] StNotFound = 2'd3;

    localparam logic OpAlloc = 1'b0;
    localparam logic OpFree  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_DONE
    } ffra_state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic shift_up;
        logic shift_down;
        logic write_new;
        logic finish;
    } ffra_cmd_t;

    typedef struct packed {
        logic is_free;
        logic early_done;
        logic hit;
        logic scan_end;
        logic shift_end;
        logic out_busy;
    } ffra_sts_t;

endpackage

// ===== hw/rtl/ffra_datapath.sv =====
// ----------------------------------------------------------------------------
// ffra_datapath
// Region table, scan pointer, gap and match checks, and the result register.
// ----------------------------------------------------------------------------
module ffra_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ffra_pkg::ffra_cmd_t  cmd,
    output ffra_pkg::ffra_sts_t  sts,
    input  logic                 in_op,
    input  logic [20:0]          in_size,
    input  logic [31:0]          in_addr,
    input  logic [31:0]          heap_base,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          out_address,
    output logic [1:0]           out_status
);
    import ffra_pkg::*;

    logic [OffW-1:0] off_mem [MaxRegions];
    logic [LenW-1:0] len_mem [MaxRegions];

    logic            op_reg;
    logic [LenW-1:0] size_reg;
    logic [31:0]     addr_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] ptr_reg;
    logic [EndW-1:0] prev_end_reg;
    logic            found_reg;
    logic            out_valid_reg;
    logic [31:0]     out_address_reg;
    logic [1:0]      out_status_reg;
    logic [1:0]      early_st;
    logic [OffW-1:0] cur_off;
    logic [LenW-1:0] cur_len;
    logic [EndW-1:0] tail_room;
    logic            at_end;
    logic            gap_fit;
    logic            tail_fit;
    logic            match;
    logic [IdxW-1:0] ptr_idx;

    // ptr_reg holds the insertion slot on alloc; the shift walks count down to it.
    logic [CntW-1:0] shift_ptr_reg;
    logic            shift_end_up;

    assign ptr_idx = ptr_reg[IdxW-1:0];
    assign cur_off = off_mem[ptr_idx];
    assign cur_len = len_mem[ptr_idx];
    assign at_end  = (ptr_reg == count_reg);
    assign shift_end_up = (shift_ptr_reg == ptr_reg);

    assign gap_fit   = ({2'b00, cur_off} >= prev_end_reg)
                    && (({2'b00, cur_off} - prev_end_reg) >= {1'b0, size_reg});
    assign tail_room = EndW'(HeapBytes) - prev_end_reg;
    assign tail_fit  = (prev_end_reg <= EndW'(HeapBytes)) && (tail_room >= {1'b0, size_reg});
    assign match     = ((heap_base + 32'(cur_off)) == addr_reg);

    always_comb
    begin
        early_st = StOk;
        if (op_reg == OpAlloc)
        begin
            if (count_reg >= CntW'(MaxRegions))
                early_st = StFull;
            else if (size_reg == '0)
                early_st = StNoFit;
        end
    end

    assign sts.is_free    = (op_reg == OpFree);
    assign sts.early_done = (early_st != StOk);
    assign sts.hit        = at_end ? (op_reg == OpAlloc && tail_fit)
                                   : (op_reg == OpAlloc ? gap_fit : match);
    assign sts.scan_end   = at_end;
    assign sts.shift_end  = cmd.shift_up ? shift_end_up
                                         : (ptr_reg + 1'b1 >= count_reg);
    assign sts.out_busy   = out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.shift_up && !shift_end_up)
        begin
            off_mem[shift_ptr_reg[IdxW-1:0]] <= off_mem[IdxW'(shift_ptr_reg - 1'b1)];
            len_mem[shift_ptr_reg[IdxW-1:0]] <= len_mem[IdxW'(shift_ptr_reg - 1'b1)];
        end
        else if (cmd.write_new)
        begin
            off_mem[ptr_idx] <= prev_end_reg[OffW-1:0];
            len_mem[ptr_idx] <= size_reg;
        end
        else if (cmd.shift_down && (ptr_reg + 1'b1 < count_reg))
        begin
            off_mem[ptr_idx] <= off_mem[IdxW'(ptr_reg + 1'b1)];
            len_mem[ptr_idx] <= len_mem[IdxW'(ptr_reg + 1'b1)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            shift_ptr_reg <= '0;
            out_valid_reg <= 1'b0;
            prev_end_reg  <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                ptr_reg      <= '0;
                prev_end_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                prev_end_reg <= {2'b00, cur_off} + {1'b0, cur_len};
                ptr_reg      <= ptr_reg + 1'b1;
                shift_ptr_reg <= count_reg;
            end
            else if (cmd.shift_up)
                shift_ptr_reg <= shift_ptr_reg - 1'b1;
            else if (cmd.shift_down)
                ptr_reg <= ptr_reg + 1'b1;
            if (cmd.load)
                shift_ptr_reg <= count_reg;
            if (cmd.load)
                found_reg <= 1'b0;
            else if (cmd.shift_up || cmd.shift_down)
                found_reg <= 1'b1;
            if (cmd.write_new)
                count_reg <= count_reg + 1'b1;
            if (cmd.shift_down && sts.shift_end)
                count_reg <= count_reg - 1'b1;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            size_reg <= in_size;
            addr_reg <= in_addr;
        end
        if (cmd.finish)
        begin
            if (found_reg)
            begin
                out_address_reg <= (op_reg == OpAlloc) ? heap_base + 32'(prev_end_reg) : '0;
                out_status_reg  <= StOk;
            end
            else if (sts.early_done)
            begin
                out_address_reg <= '0;
                out_status_reg  <= early_st;
            end
            else if (op_reg == OpAlloc)
            begin
                out_address_reg <= '0;
                out_status_reg  <= StNoFit;
            end
            else
            begin
                out_address_reg <= '0;
                out_status_reg  <= StNotFound;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_address = out_address_reg;
    assign out_status  = out_status_reg;

endmodule

// ===== hw/rtl/ffra_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer: accept, scan, shift the table, then post the result.
// ----------------------------------------------------------------------------
module ffra_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ffra_pkg::ffra_sts_t  sts,
    output ffra_pkg::ffra_cmd_t  cmd
);
    import ffra_pkg::*;

    ffra_state_t state_reg;
    ffra_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_SCAN;
            S_SCAN:
                if (sts.early_done)
                    state_next = S_DONE;
                else if (sts.hit)
                    state_next = sts.is_free ? S_SHIFT_DOWN : S_SHIFT_UP;
                else if (sts.scan_end)
                    state_next = S_DONE;
            S_SHIFT_UP:
                if (sts.shift_end)
                    state_next = S_DONE;
            S_SHIFT_DOWN:
                if (sts.shift_end)
                    state_next = S_DONE;
            S_DONE:
                if (!sts.out_busy)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SCAN:
                cmd.scan_step = !sts.early_done && !sts.hit && !sts.scan_end;
            S_SHIFT_UP:
            begin
                cmd.shift_up  = 1'b1;
                cmd.write_new = sts.shift_end;
            end
            S_SHIFT_DOWN:
                cmd.shift_down = 1'b1;
            S_DONE:
                cmd.finish = !sts.out_busy;
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/first_fit_region_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// First-fit allocator over a sorted table of up to sixteen heap regions.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel, one transaction per request, and
// each produces exactly one response transaction on m_axis.
// An allocate scans the table for the first gap that fits, then moves
// entries up one place to open the slot; a free scans for the address and
// closes up the table. The scan and the shift each step one entry a cycle;
// the response is registered once the walk of the table is done, and the
// next request is taken after that.
// heap_base is to be written over the APB port only while no request is
// in flight; the block itself does not enforce this.
// Reset empties the table and clears heap_base.
// A stalled m_axis holds its response; a new request is taken only after
// the previous response has been registered.
// ----------------------------------------------------------------------------
module first_fit_region_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // request_size[20:0], free_address[52:21], zero pad
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // granted_address[31:0], status[33:32], zero pad
);
    import ffra_pkg::*;

    localparam logic [1:0] AddrHeapBase = 2'd0;

    logic [31:0] heap_base_reg;
    ffra_cmd_t   cmd;
    ffra_sts_t   sts;
    logic [31:0] out_address;
    logic [1:0]  out_status;

    assign pready = 1'b1;
    assign prdata = (paddr == AddrHeapBase) ? heap_base_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            heap_base_reg <= '0;
        else if (psel && penable && pwrite && paddr == AddrHeapBase)
            heap_base_reg <= pwdata;
    end

    ffra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffra_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_op       (s_axis_tuser),
        .in_size     (s_axis_tdata[20:0]),
        .in_addr     (s_axis_tdata[52:21]),
        .heap_base   (heap_base_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_address (out_address),
        .out_status  (out_status)
    );

    assign m_axis_tdata = {6'b0, out_status, out_address};

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan_step, cmd.shift_up, cmd.shift_down, cmd.finish}))
        else $error("conflicting datapath commands");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !s_axis_tready)
        else $error("request accepted while finishing");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_axis_tvalid)
        else $error("response not posted");

endmodule
